### design/wsss_pkg.sv
// Shared constants and types for the weighted Sidon set search unit.
package wsss_pkg;
    localparam int unsigned WEIGHT_W = 32;
    localparam int unsigned TOTAL_W  = 37;
    localparam int unsigned COUNT_W  = 64;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned RANGE_W  = 8;
    localparam int unsigned SIZE_W   = 5;
    localparam int unsigned SUM_W    = 8;
    localparam logic [RANGE_W-1:0] RANGE_RESET = 8'd84;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 5'd10;
    localparam logic CFG_RANGE = 1'b0;
    localparam logic CFG_SIZE  = 1'b1;

    typedef logic [COUNT_W-1:0] t_count;

    function automatic t_count sat_inc(input t_count v);
        sat_inc = (&v) ? v : v + t_count'(1);
    endfunction
endpackage

### design/weighted_sidon_set_search_unit.sv
// Top level of the weighted Sidon set search unit.
// Input channel: one 32-bit weight per transfer (i_valid / o_stall), positions
// ascending from 0, one per cycle while o_stall is low. The transfer that
// completes a load (position + 1 >= range size) starts a search; o_stall
// stays high until every result has been transferred and S_CLR has passed.
// After reset, S_INIT clears all 256 sum-mark addresses with o_stall high.
// The search walks the span-ordered backtracking tree one candidate at a time.
// Each span sets three base marks in S_SINIT and releases two in S_SCLR. A
// candidate test reads used + 2 marks, one per cycle, and S_TESTW checks the
// last read; marking and unmarking each write used + 2 marks, one per cycle.
// Each found set is scored over every shift that fits in the range, one weight
// read per cycle. Total latency depends on range and set size and can be very
// large.
// Output channel: set_size results (o_valid / i_stall), one per cycle while not
// stalled, the last flagged by o_last_element. A stalled result holds.
// Configuration (i_cfg_valid / o_cfg_ready, index 0 range_size, 1 set_size) is
// always ready; range_size is checked on every weight transfer, set_size is
// taken when a search starts.
module weighted_sidon_set_search_unit
    import wsss_pkg::*;
#(
    parameter int MAX_RANGE    = 128,
    parameter int MAX_SET_SIZE = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [WEIGHT_W-1:0]       i_weight_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [IDX_W-1:0]          o_element_index,
    output logic [POS_W-1:0]          o_element_value,
    output logic signed [TOTAL_W-1:0] o_best_weight,
    output logic [COUNT_W-1:0]        o_normalized_count,
    output logic [COUNT_W-1:0]        o_set_count,
    output logic [COUNT_W-1:0]        o_node_count,
    output logic                      o_last_element,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [RANGE_W-1:0]        i_cfg_data
);
    localparam int AW = $clog2(MAX_RANGE);
    localparam int KW = $clog2(MAX_SET_SIZE);

    typedef enum logic [4:0] {
        S_INIT, S_LOAD, S_SPAN, S_SINIT, S_NODE, S_CAND, S_TEST, S_TESTW, S_MARK,
        S_DESC, S_SCORE, S_SRD, S_SACC, S_SCMP, S_RET, S_UNMARK, S_SCLR, S_NEXT,
        S_CLR, S_OUT
    } t_state;

    t_state r_state;
    logic [RANGE_W-1:0] r_range;
    logic [SIZE_W-1:0]  r_size;
    logic [7:0]  r_n;
    logic [4:0]  r_k;
    logic [AW-1:0] r_load;
    logic [7:0]  r_high;
    logic [7:0]  r_x [MAX_SET_SIZE];
    logic [7:0]  r_stk [MAX_SET_SIZE];
    logic [7:0]  r_best [MAX_SET_SIZE];
    logic [4:0]  r_used;
    logic [4:0]  r_i;
    logic [7:0]  r_shift;
    logic [TOTAL_W-1:0] r_sum;
    logic signed [TOTAL_W-1:0] r_btot;
    logic        r_ok;
    logic [7:0]  r_clr;
    t_count      r_nnorm, r_ntrans, r_nodes;

    logic [KW-1:0] r_oidx;

    logic           mem_we;
    logic [AW-1:0]  mem_ra;
    logic [WEIGHT_W-1:0] mem_rd;

    logic             mk_we;
    logic             mk_wdata;
    logic [SUM_W-1:0] mk_waddr;
    logic [SUM_W-1:0] mk_raddr;
    logic             mk_rdata;

    logic [7:0] eff_n;
    logic [4:0] eff_k;
    always_comb begin
        eff_n = (r_range < 8'd2) ? 8'd2 :
                (r_range > 8'(MAX_RANGE)) ? 8'(MAX_RANGE) : r_range;
        eff_k = (r_size < 5'd2) ? 5'd2 :
                (r_size > 5'(MAX_SET_SIZE)) ? 5'(MAX_SET_SIZE) : r_size;
    end

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_LOAD);
    assign mem_we      = (r_state == S_LOAD) && i_valid;

    wsss_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_RANGE)) u_weights (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_load),
        .i_wdata(i_weight_value),
        .i_raddr(mem_ra),
        .o_rdata(mem_rd)
    );

    wsss_ram #(.WIDTH(1), .DEPTH(256)) u_marks (
        .i_clk  (i_clk),
        .i_we   (mk_we),
        .i_waddr(mk_waddr),
        .i_wdata(mk_wdata),
        .i_raddr(mk_raddr),
        .o_rdata(mk_rdata)
    );

    // remaining = k-1-used; upper = high - rem*(rem+1)/2
    logic [4:0] rem;
    logic [8:0] tri_rem;
    logic signed [9:0] upper;
    logic [7:0] cur_x;
    logic [7:0] elem_i;
    logic [7:0] psum;
    logic [7:0] stk_sh;
    logic [SUM_W-1:0] span_addr;
    logic [SUM_W-1:0] mark_addr;
    assign rem     = r_k - 5'd1 - r_used;
    assign tri_rem = ({4'b0, rem} * {4'b0, rem + 5'd1}) >> 1;
    assign upper   = $signed({2'b0, r_high}) - $signed({1'b0, tri_rem});
    assign cur_x   = r_x[r_used[KW-1:0]];
    assign elem_i  = r_stk[r_i[KW-1:0]];
    assign psum    = elem_i + cur_x;
    assign stk_sh  = elem_i + r_shift;
    assign mem_ra  = stk_sh[AW-1:0];

    assign span_addr = (r_i == 5'd0) ? 8'd0 :
                       (r_i == 5'd1) ? r_high : {r_high[6:0], 1'b0};
    assign mark_addr = (r_i < r_used)  ? psum :
                       (r_i == r_used) ? 8'(r_high + cur_x) : {cur_x[6:0], 1'b0};
    assign mk_raddr  = mark_addr;

    always_comb begin
        mk_we    = 1'b0;
        mk_wdata = 1'b0;
        mk_waddr = mark_addr;
        unique case (r_state)
            S_INIT: begin
                mk_we    = 1'b1;
                mk_waddr = r_clr;
            end
            S_SINIT: begin
                mk_we    = 1'b1;
                mk_wdata = 1'b1;
                mk_waddr = span_addr;
            end
            S_SCLR: begin
                mk_we    = 1'b1;
                mk_waddr = span_addr;
            end
            S_MARK: begin
                mk_we    = 1'b1;
                mk_wdata = 1'b1;
            end
            S_UNMARK: begin
                mk_we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sums (< 256) go through the mark memory; k-1 top element is at r_high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_clr    <= '0;
            r_range  <= RANGE_RESET;
            r_size   <= SIZE_RESET;
            r_load   <= '0;
            r_btot   <= '1;
            r_nnorm  <= '0;
            r_ntrans <= '0;
            r_nodes  <= '0;
            r_oidx   <= '0;
            o_valid  <= 1'b0;
            r_k      <= 5'd2;
            r_n      <= 8'd2;
            for (int j = 0; j < MAX_SET_SIZE; j++) begin
                r_best[j] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_RANGE) r_range <= i_cfg_data;
                else                          r_size  <= i_cfg_data[SIZE_W-1:0];
            end
            unique case (r_state)
                S_INIT: begin
                    if (r_clr == 8'hFF) r_state <= S_LOAD;
                    r_clr <= r_clr + 8'd1;
                end
                S_LOAD: begin
                    if (i_valid) begin
                        if ({1'b0, r_load} + 9'd1 < {1'b0, eff_n}) begin
                            r_load <= r_load + AW'(1);
                        end else begin
                            r_load   <= '0;
                            r_n      <= eff_n;
                            r_k      <= eff_k;
                            r_btot   <= '1;
                            r_nnorm  <= '0;
                            r_ntrans <= '0;
                            r_nodes  <= '0;
                            for (int j = 0; j < MAX_SET_SIZE; j++) begin
                                r_best[j] <= '0;
                            end
                            r_high  <= ({3'b0, eff_k} * {3'b0, eff_k - 5'd1}) >> 1;
                            r_state <= S_SPAN;
                        end
                    end
                end
                S_SPAN: begin
                    if (r_high >= r_n) begin
                        r_oidx  <= '0;
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_stk[0] <= 8'd0;
                        r_stk[r_k[KW-1:0] - KW'(1)] <= r_high;
                        r_used  <= 5'd1;
                        r_x[1]  <= 8'd1;
                        r_i     <= '0;
                        r_state <= S_SINIT;
                    end
                end
                S_SINIT: begin
                    if (r_i == 5'd2) r_state <= S_NODE;
                    else             r_i <= r_i + 5'd1;
                end
                S_NODE: begin
                    r_nodes <= sat_inc(r_nodes);
                    if (r_used == r_k - 5'd1) r_state <= S_SCORE;
                    else                      r_state <= S_CAND;
                    r_shift <= '0;
                end
                S_CAND: begin
                    if ($signed({2'b0, cur_x}) > upper) begin
                        r_state <= S_RET;
                    end else begin
                        r_i  <= '0;
                        r_ok <= (r_high != cur_x);
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (r_i != 5'd0 && mk_rdata) r_ok <= 1'b0;
                    if (r_i == r_used + 5'd1) r_state <= S_TESTW;
                    else                      r_i <= r_i + 5'd1;
                end
                S_TESTW: begin
                    r_i <= '0;
                    if (r_ok && !mk_rdata) r_state <= S_MARK;
                    else                   r_state <= S_NEXT;
                end
                S_MARK: begin
                    if (r_i == r_used + 5'd1) begin
                        r_stk[r_used[KW-1:0]] <= cur_x;
                        r_state <= S_DESC;
                    end else begin
                        r_i <= r_i + 5'd1;
                    end
                end
                S_DESC: begin
                    if (r_used + 5'd1 < 5'(MAX_SET_SIZE)) begin
                        r_x[r_used[KW-1:0] + KW'(1)] <= cur_x + 8'd1;
                    end
                    r_used  <= r_used + 5'd1;
                    r_state <= S_NODE;
                end
                S_SCORE: begin
                    r_nnorm <= sat_inc(r_nnorm);
                    r_shift <= '0;
                    r_i     <= '0;
                    r_state <= S_SRD;
                end
                S_SRD: begin
                    if ({1'b0, r_shift} + {1'b0, r_high} >= {1'b0, r_n}) begin
                        r_state <= S_RET;
                    end else begin
                        r_i   <= 5'd1;
                        r_sum <= '0;
                        r_state <= S_SACC;
                    end
                end
                S_SACC: begin
                    // r_i-1 data present; address r_i issued
                    r_sum <= r_sum + TOTAL_W'(mem_rd);
                    if (r_i == r_k) r_state <= S_SCMP;
                    else            r_i <= r_i + 5'd1;
                end
                S_SCMP: begin
                    r_ntrans <= sat_inc(r_ntrans);
                    if ($signed(r_sum) > r_btot) begin
                        r_btot <= $signed(r_sum);
                        for (int j = 0; j < MAX_SET_SIZE; j++) begin
                            r_best[j] <= r_stk[j] + r_shift;
                        end
                    end
                    r_shift <= r_shift + 8'd1;
                    r_i     <= '0;
                    r_state <= S_SRD;
                end
                S_RET: begin
                    if (r_used == 5'd1) begin
                        r_i     <= 5'd1;
                        r_state <= S_SCLR;
                    end else begin
                        r_used <= r_used - 5'd1;
                        r_i    <= '0;
                        r_state <= S_UNMARK;
                    end
                end
                S_UNMARK: begin
                    if (r_i == r_used + 5'd1) r_state <= S_NEXT;
                    else                      r_i <= r_i + 5'd1;
                end
                S_SCLR: begin
                    if (r_i == 5'd2) begin
                        r_high  <= r_high + 8'd1;
                        r_state <= S_SPAN;
                    end else begin
                        r_i <= r_i + 5'd1;
                    end
                end
                S_NEXT: begin
                    r_x[r_used[KW-1:0]] <= cur_x + 8'd1;
                    r_state <= S_CAND;
                end
                S_CLR: begin
                    r_state <= S_LOAD;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if ({1'b0, r_oidx} + 5'd1 == r_k) begin
                            o_valid <= 1'b0;
                            r_state <= S_CLR;
                        end else begin
                            r_oidx <= r_oidx + KW'(1);
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_comb begin
        o_element_index    = IDX_W'(r_oidx);
        o_element_value    = r_best[r_oidx][POS_W-1:0];
        o_best_weight      = r_btot;
        o_normalized_count = r_nnorm;
        o_set_count        = r_ntrans;
        o_node_count       = r_nodes;
        o_last_element     = ({1'b0, r_oidx} + 5'd1 == r_k);
    end
endmodule

### design/wsss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wsss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### tb/weighted_sidon_set_search_unit_tb.sv
// Testbench for the weighted Sidon set search unit: loads, searches and results checked
`timescale 1ns / 100ps

module weighted_sidon_set_search_unit_tb;
    import wsss_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [POS_W-1:0]   pos;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] norm;
        logic [COUNT_W-1:0] shifted;
        logic [COUNT_W-1:0] nodes;
        logic               last;
    } t_element;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [WEIGHT_W-1:0]       i_weight_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [IDX_W-1:0]          o_element_index;
    logic [POS_W-1:0]          o_element_value;
    logic signed [TOTAL_W-1:0] o_best_weight;
    logic [COUNT_W-1:0]        o_normalized_count;
    logic [COUNT_W-1:0]        o_set_count;
    logic [COUNT_W-1:0]        o_node_count;
    logic                      o_last_element;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic                      i_cfg_index = CFG_RANGE;
    logic [RANGE_W-1:0]        i_cfg_data = '0;

    weighted_sidon_set_search_unit u_dut (.*);

    always #2 i_clk = ~i_clk;

    // search predictor state
    logic [WEIGHT_W-1:0] weights [128];
    int                  fill_pos;
    logic [RANGE_W-1:0]  range_reg = RANGE_RESET;
    logic [SIZE_W-1:0]   size_reg = SIZE_RESET;
    int                  n_pos, k_len, span;
    int                  chosen [16];
    int                  best_pos [16];
    bit [255:0]          sum_seen;
    longint              best_sum;
    logic [COUNT_W-1:0]  cnt_norm, cnt_shift, cnt_nodes;

    t_element expected_elements [$];
    int       errors = 0;
    int       burst_left = 0;
    int       hold_request = 0;
    int       hold_left = 0;
    int       stall_mode = 0;
    int       stall_phase = 0;

    function automatic void score_ruler();
        longint sum;
        cnt_norm = sat_inc(cnt_norm);
        for (int sh = 0; sh + span < n_pos; sh++) begin
            sum = 0;
            for (int i = 0; i < k_len; i++) sum += weights[(chosen[i] + sh) & 127];
            cnt_shift = sat_inc(cnt_shift);
            if (sum > best_sum) begin
                best_sum = sum;
                for (int i = 0; i < k_len; i++) best_pos[i] = chosen[i] + sh;
            end
        end
    endfunction

    function automatic void walk_tree(int used, int first, int remaining);
        int  upper;
        bit  ok;
        int  diag;
        cnt_nodes = sat_inc(cnt_nodes);
        if (remaining == 0) begin
            score_ruler();
            return;
        end
        upper = span - remaining * (remaining + 1) / 2;
        for (int x = first; x <= upper; x++) begin
            ok = 1;
            diag = 2 * x;
            for (int i = 0; i < used; i++)
                if (sum_seen[chosen[i] + x] || chosen[i] + x == diag) ok = 0;
            if (sum_seen[span + x] || span + x == diag) ok = 0;
            if (sum_seen[diag]) ok = 0;
            if (ok) begin
                for (int i = 0; i < used; i++) sum_seen[chosen[i] + x] = 1;
                sum_seen[span + x] = 1;
                sum_seen[diag] = 1;
                chosen[used] = x;
                walk_tree(used + 1, x + 1, remaining - 1);
                for (int i = 0; i < used; i++) sum_seen[chosen[i] + x] = 0;
                sum_seen[span + x] = 0;
                sum_seen[diag] = 0;
            end
        end
    endfunction

    function automatic void predict_weight(logic [WEIGHT_W-1:0] w);
        t_element e;
        n_pos = (range_reg < 2) ? 2 : (range_reg > 128) ? 128 : int'(range_reg);
        k_len = (size_reg < 2) ? 2 : (size_reg > 16) ? 16 : int'(size_reg);
        weights[fill_pos & 127] = w;
        if ((fill_pos & 127) + 1 < n_pos) begin
            fill_pos = (fill_pos + 1) & 127;
            return;
        end
        fill_pos = 0;
        best_sum = -1;
        for (int i = 0; i < 16; i++) best_pos[i] = 0;
        cnt_norm = '0;
        cnt_shift = '0;
        cnt_nodes = '0;
        for (int hi = k_len * (k_len - 1) / 2; hi < n_pos; hi++) begin
            span = hi;
            sum_seen = '0;
            sum_seen[0] = 1;
            sum_seen[hi] = 1;
            sum_seen[2 * hi] = 1;
            chosen[0] = 0;
            chosen[k_len - 1] = hi;
            walk_tree(1, 1, k_len - 2);
        end
        for (int i = 0; i < k_len; i++) begin
            e.idx = IDX_W'(i);
            e.pos = POS_W'(best_pos[i]);
            e.total = best_sum[TOTAL_W-1:0];
            e.norm = cnt_norm;
            e.shifted = cnt_shift;
            e.nodes = cnt_nodes;
            e.last = (i == k_len - 1);
            expected_elements.push_back(e);
        end
    endfunction

    task automatic send_weight(input logic [WEIGHT_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            repeat (gap) begin
                i_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid = 1'b1;
        i_weight_value = w;
        do @(posedge i_clk); while (o_stall);
        predict_weight(w);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [RANGE_W-1:0] data);
        i_valid = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_RANGE) range_reg = data;
        else size_reg = data[SIZE_W-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (expected_elements.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_range(input int count);
        repeat (count) send_weight(rand_weight());
        drain();
    endtask

    task automatic test_extremes();
        write_reg(CFG_RANGE, 8'd0);
        write_reg(CFG_SIZE, 8'd1);
        send_weight('1);
        send_weight('0);
        drain();
        write_reg(CFG_RANGE, 8'd8);
        write_reg(CFG_SIZE, 8'd31);
        repeat (8) send_weight('1);
        drain();
        write_reg(CFG_SIZE, 8'd16);
        repeat (8) send_weight('0);
        drain();
        write_reg(CFG_RANGE, 8'd7);
        write_reg(CFG_SIZE, 8'd3);
        load_range(7);
    endtask

    task automatic test_midload_resize();
        write_reg(CFG_RANGE, 8'd10);
        write_reg(CFG_SIZE, 8'd3);
        repeat (5) send_weight(rand_weight());
        drain();
        write_reg(CFG_RANGE, 8'd4);
        send_weight(rand_weight());
        drain();
    endtask

    task automatic test_max_range();
        write_reg(CFG_RANGE, 8'd255);
        write_reg(CFG_SIZE, 8'd2);
        load_range(128);
        write_reg(CFG_RANGE, 8'd128);
        write_reg(CFG_SIZE, 8'd0);
        load_range(128);
    endtask

    task automatic test_long_hold();
        write_reg(CFG_RANGE, 8'd12);
        write_reg(CFG_SIZE, 8'd4);
        hold_request = 1;
        repeat (24) send_weight(rand_weight());
        drain();
    endtask

    task automatic test_random_loads();
        int sent;
        int n;
        sent = 0;
        while (sent < 140) begin
            case ($urandom_range(0, 3))
                0: begin n = $urandom_range(2, 24); write_reg(CFG_SIZE, 8'd2); end
                1: begin n = $urandom_range(3, 16); write_reg(CFG_SIZE, 8'd3); end
                2: begin n = $urandom_range(6, 16); write_reg(CFG_SIZE, 8'd4); end
                default: begin n = $urandom_range(11, 14); write_reg(CFG_SIZE, 8'd5); end
            endcase
            write_reg(CFG_RANGE, RANGE_W'(n));
            load_range(n);
            sent += n;
        end
    endtask

    always @(negedge i_clk) begin
        stall_phase = stall_phase + 1;
        if (stall_phase % 150 == 0) stall_mode = $urandom_range(0, 3);
        if (hold_request != 0) begin
            hold_request = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall = 1'b1;
        end else begin
            case (stall_mode)
                0: i_stall = 1'b0;
                1: i_stall = ($urandom_range(0, 1) == 0);
                2: i_stall = ($urandom_range(0, 4) != 0);
                default: i_stall = (stall_phase % 4 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_element e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_elements.size() == 0) begin
                $error("unexpected result transfer, element_index %0d", o_element_index);
                errors++;
            end else begin
                e = expected_elements.pop_front();
                if (o_element_index !== e.idx) begin
                    $error("element_index exp %0d got %0d", e.idx, o_element_index);
                    errors++;
                end
                if (o_element_value !== e.pos) begin
                    $error("element_value exp %0d got %0d", e.pos, o_element_value);
                    errors++;
                end
                if (o_best_weight !== e.total) begin
                    $error("best_weight exp %h got %h", e.total, o_best_weight);
                    errors++;
                end
                if (o_normalized_count !== e.norm) begin
                    $error("normalized_count exp %0d got %0d", e.norm, o_normalized_count);
                    errors++;
                end
                if (o_set_count !== e.shifted) begin
                    $error("set_count exp %0d got %0d", e.shifted, o_set_count);
                    errors++;
                end
                if (o_node_count !== e.nodes) begin
                    $error("node_count exp %0d got %0d", e.nodes, o_node_count);
                    errors++;
                end
                if (o_last_element !== e.last) begin
                    $error("last_element exp %0d got %0d", e.last, o_last_element);
                    errors++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        fill_pos = 0;
        for (int i = 0; i < 128; i++) weights[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_midload_resize();
        test_long_hold();
        test_max_range();
        test_random_loads();
        drain();
        repeat (50) @(negedge i_clk);
        if (errors == 0 && expected_elements.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### filelist.f
design/wsss_pkg.sv
design/wsss_ram.sv
design/weighted_sidon_set_search_unit.sv
tb/weighted_sidon_set_search_unit_tb.sv
